/* design/matrix_segment_tree_path_counter_defines.svh */
// Assertion macros used by the path counter top level.
`ifndef MATRIX_SEGMENT_TREE_PATH_COUNTER_DEFINES_SVH
`define MATRIX_SEGMENT_TREE_PATH_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define MSTP_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define MSTP_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mstp_pkg.sv */
// Types, constants and matrices shared by the path counter modules.
package mstp_pkg;

    localparam int VAL_W = 30;
    localparam int CFG_W = 11;
    localparam int IDX_W = 10;
    localparam int DEF_MAX_CELLS = 1024;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [VAL_W-1:0] P_MOD = 30'd1000000007;
    localparam logic [63:0] MU_WIDE = 64'h1000_0000_0000_0000 / 64'd1000000007;
    localparam logic [30:0] MU = MU_WIDE[30:0];

    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_TOGGLE = 1'b1;

    typedef logic [8:0][VAL_W-1:0] t_mat;

    localparam t_mat MAT_E = '{30'd1, 30'd1, 30'd0, 30'd1, 30'd0, 30'd1, 30'd1, 30'd0, 30'd0};
    localparam t_mat MAT_Z = '{30'd0, 30'd1, 30'd0, 30'd0, 30'd0, 30'd1, 30'd0, 30'd0, 30'd0};
    localparam t_mat MAT_I = '{30'd1, 30'd0, 30'd0, 30'd0, 30'd1, 30'd0, 30'd0, 30'd0, 30'd1};

    typedef enum logic [3:0] {
        ST_LEAF,
        ST_RDL,
        ST_RDR,
        ST_CAP,
        ST_MUL,
        ST_IDLE,
        ST_TRD,
        ST_TWR,
        ST_DONE
    } t_state;

endpackage

/* design/mstp_mulmod.sv */
// Four-stage pipelined modular multiplier with Barrett reduction.
module mstp_mulmod
    import mstp_pkg::*;
#(
    parameter int TAG_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [TAG_W-1:0] i_tag,
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    output logic             o_valid,
    output logic [TAG_W-1:0] o_tag,
    output logic [VAL_W-1:0] o_r
);

    logic [59:0]      r_x;
    logic [61:0]      r_q2;
    logic [31:0]      r_xl2;
    logic [31:0]      r_xl3;
    logic [31:0]      r_qp;
    logic [VAL_W-1:0] r_r;
    logic [3:0]       r_vld;
    logic [3:0][TAG_W-1:0] r_tag;

    logic [61:0] w_qp_full;
    logic [31:0] w_d;
    logic [31:0] w_p32;

    assign w_p32 = {2'b00, P_MOD};
    assign w_qp_full = {31'd0, r_q2[61:31]} * {32'd0, P_MOD};
    assign w_d = r_xl3 - r_qp;

    always_ff @(posedge i_clk) begin
        r_x   <= {30'd0, i_a} * {30'd0, i_b};
        r_q2  <= {31'd0, r_x[59:29]} * {31'd0, MU};
        r_xl2 <= r_x[31:0];
        r_qp  <= w_qp_full[31:0];
        r_xl3 <= r_xl2;
        if (w_d >= {w_p32[30:0], 1'b0}) begin
            r_r <= VAL_W'(w_d - {w_p32[30:0], 1'b0});
        end else if (w_d >= w_p32) begin
            r_r <= VAL_W'(w_d - w_p32);
        end else begin
            r_r <= VAL_W'(w_d);
        end
        r_tag <= {r_tag[2:0], i_tag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign o_valid = r_vld[3];
    assign o_tag   = r_tag[3];
    assign o_r     = r_r;

endmodule

/* design/mstp_matmul.sv */
// Sequencer and accumulator for one 3x3 modular matrix product.
module mstp_matmul
    import mstp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_mat i_a,
    input  t_mat i_b,
    output logic o_done,
    output t_mat o_res
);

    logic             r_busy;
    logic [1:0]       r_i;
    logic [1:0]       r_j;
    logic [1:0]       r_k;
    logic [VAL_W-1:0] r_acc;
    t_mat             r_res;
    logic             r_done;

    logic [3:0]       w_ai;
    logic [3:0]       w_bi;
    logic [3:0]       w_e;
    logic [5:0]       w_tag;
    logic             w_ovld;
    logic [5:0]       w_otag;
    logic [VAL_W-1:0] w_or;
    logic [VAL_W:0]   w_sum;
    logic [VAL_W-1:0] w_red;

    assign w_ai  = {2'b00, r_i} * 4'd3 + {2'b00, r_k};
    assign w_bi  = {2'b00, r_k} * 4'd3 + {2'b00, r_j};
    assign w_e   = {2'b00, r_i} * 4'd3 + {2'b00, r_j};
    assign w_tag = {w_e, (r_k == 2'd0), (r_k == 2'd2)};

    mstp_mulmod #(.TAG_W(6)) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_busy),
        .i_tag   (w_tag),
        .i_a     (i_a[w_ai]),
        .i_b     (i_b[w_bi]),
        .o_valid (w_ovld),
        .o_tag   (w_otag),
        .o_r     (w_or)
    );

    assign w_sum = (w_otag[1] ? {(VAL_W+1){1'b0}} : {1'b0, r_acc}) + {1'b0, w_or};
    assign w_red = (w_sum >= {1'b0, P_MOD}) ? VAL_W'(w_sum - {1'b0, P_MOD}) : VAL_W'(w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
            r_j    <= '0;
            r_k    <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= w_ovld && w_otag[0] && (w_otag[5:2] == 4'd8);
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_j    <= '0;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_k == 2'd2) begin
                    r_k <= '0;
                    if (r_j == 2'd2) begin
                        r_j <= '0;
                        if (r_i == 2'd2) begin
                            r_busy <= 1'b0;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end else begin
                    r_k <= r_k + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ovld) begin
            r_acc <= w_red;
            if (w_otag[0]) begin
                r_res[w_otag[5:2]] <= w_red;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* design/matrix_segment_tree_path_counter.sv */
// Top level: segment tree of 3x3 matrices mod 1000000007 counting paths over a row of cells.
// A query moves to the DONE state, which registers the answer once the output can take it;
// a toggle walks log2(MAX_CELLS) levels. Each level reads both children (states RDL, RDR
// and CAP) and runs 27 products through the multiplier; after the root a toggle answers from DONE.
// Reset and every cell_count write rebuild the tree: one leaf a cycle, then one combine per
// node, with no input accepted; reset also clears all blocks.
module matrix_segment_tree_path_counter
    import mstp_pkg::*;
#(
    parameter int MAX_CELLS = DEF_MAX_CELLS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_cmd,
    input  logic [IDX_W-1:0] i_cell_index,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [VAL_W-1:0] o_ways,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

`include "matrix_segment_tree_path_counter_defines.svh"

    localparam int LW = $clog2(MAX_CELLS);
    localparam int NW = LW + 1;

    t_mat            r_tree [2**NW];
    logic            r_blk  [2**LW];

    t_state          r_state;
    t_state          n_state;
    logic [LW:0]     r_cnt;
    logic            r_lf_vld;
    logic [LW-1:0]   r_lf_idx;
    logic            r_clear;
    logic            r_rebuild;
    logic [NW-1:0]   r_node;
    logic [LW-1:0]   r_idx;
    logic [CFG_W-1:0] r_cell_count;
    logic [VAL_W-1:0] r_root22;
    t_mat            r_a;
    t_mat            r_b;
    t_mat            r_tree_rd;
    logic            r_blk_rd;
    logic            r_out_valid;
    logic [VAL_W-1:0] r_ways;

    logic            w_tree_we;
    logic [NW-1:0]   w_tree_wa;
    t_mat            w_tree_wd;
    logic [NW-1:0]   w_tree_ra;
    logic            w_blk_we;
    logic [LW-1:0]   w_blk_wa;
    logic            w_blk_wd;
    logic [LW-1:0]   w_blk_ra;
    logic            w_mm_start;
    logic            w_mm_done;
    t_mat            w_mm_res;
    logic            w_out_load;
    logic            w_cfg_wr;
    logic            w_in_acc;
    logic            w_toggle_ok;
    logic [CFG_W-1:0] w_live;
    logic            w_lf_blk;
    logic            w_lf_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_live      = ({21'd0, r_cell_count} > 32'(MAX_CELLS)) ? CFG_W'(MAX_CELLS)
                                                                   : r_cell_count;
    assign w_toggle_ok = (i_cmd == CMD_TOGGLE) && ({1'b0, i_cell_index} < w_live);
    assign w_lf_blk    = r_clear ? 1'b0 : r_blk_rd;
    assign w_lf_last   = r_lf_vld && (r_lf_idx == {LW{1'b1}});

    mstp_matmul u_matmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mm_start),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_done  (w_mm_done),
        .o_res   (w_mm_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LEAF: begin
                if (w_lf_last) n_state = ST_RDL;
            end
            ST_RDL: n_state = ST_RDR;
            ST_RDR: n_state = ST_CAP;
            ST_CAP: n_state = ST_MUL;
            ST_MUL: begin
                if (w_mm_done) begin
                    if (r_node == NW'(1)) begin
                        n_state = r_rebuild ? ST_IDLE : ST_DONE;
                    end else begin
                        n_state = ST_RDL;
                    end
                end
            end
            ST_IDLE: begin
                if (w_in_acc) n_state = w_toggle_ok ? ST_TRD : ST_DONE;
            end
            ST_TRD: n_state = ST_TWR;
            ST_TWR: n_state = ST_RDL;
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        if (w_cfg_wr) n_state = ST_LEAF;
    end

    always_comb begin
        w_tree_we  = 1'b0;
        w_tree_wa  = '0;
        w_tree_wd  = MAT_I;
        w_tree_ra  = '0;
        w_blk_we   = 1'b0;
        w_blk_wa   = '0;
        w_blk_wd   = 1'b0;
        w_blk_ra   = '0;
        w_mm_start = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_LEAF: begin
                w_blk_ra = r_cnt[LW-1:0];
                if (r_lf_vld) begin
                    w_tree_we = 1'b1;
                    w_tree_wa = {1'b1, r_lf_idx};
                    if (32'(r_lf_idx) < 32'(w_live)) begin
                        w_tree_wd = w_lf_blk ? MAT_Z : MAT_E;
                    end
                    w_blk_we = r_clear;
                    w_blk_wa = r_lf_idx;
                end
            end
            ST_RDL: w_tree_ra = {r_node[NW-2:0], 1'b0};
            ST_RDR: w_tree_ra = {r_node[NW-2:0], 1'b1};
            ST_CAP: w_mm_start = 1'b1;
            ST_MUL: begin
                w_tree_we = w_mm_done;
                w_tree_wa = r_node;
                w_tree_wd = w_mm_res;
            end
            ST_TRD: w_blk_ra = r_idx;
            ST_TWR: begin
                w_blk_we  = 1'b1;
                w_blk_wa  = r_idx;
                w_blk_wd  = !r_blk_rd;
                w_tree_we = 1'b1;
                w_tree_wa = {1'b1, r_idx};
                w_tree_wd = r_blk_rd ? MAT_E : MAT_Z;
            end
            ST_DONE: w_out_load = !r_out_valid || !i_out_stall;
            default: w_out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_tree_we) r_tree[w_tree_wa] <= w_tree_wd;
        r_tree_rd <= r_tree[w_tree_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_blk_we) r_blk[w_blk_wa] <= w_blk_wd;
        r_blk_rd <= r_blk[w_blk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RDR) r_a <= r_tree_rd;
        if (r_state == ST_CAP) r_b <= r_tree_rd;
        if (r_state == ST_MUL && w_mm_done && r_node == NW'(1)) r_root22 <= w_mm_res[8];
        if (w_in_acc) r_idx <= LW'(i_cell_index);
        if (w_out_load) r_ways <= (w_live == '0) ? '0 : r_root22;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LEAF;
            r_cnt        <= '0;
            r_lf_vld     <= 1'b0;
            r_lf_idx     <= '0;
            r_clear      <= 1'b1;
            r_rebuild    <= 1'b1;
            r_node       <= '0;
            r_cell_count <= CFG_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                r_cell_count <= i_cfg_data;
                r_cnt        <= '0;
                r_lf_vld     <= 1'b0;
                r_rebuild    <= 1'b1;
            end else begin
                case (r_state)
                    ST_LEAF: begin
                        if (!r_cnt[LW]) r_cnt <= r_cnt + 1'b1;
                        r_lf_vld <= !r_cnt[LW];
                        r_lf_idx <= r_cnt[LW-1:0];
                        if (w_lf_last) begin
                            r_node  <= {1'b0, {LW{1'b1}}};
                            r_clear <= 1'b0;
                        end
                    end
                    ST_MUL: begin
                        if (w_mm_done) begin
                            r_node <= r_rebuild ? r_node - 1'b1 : r_node >> 1;
                        end
                    end
                    ST_IDLE: begin
                        if (w_in_acc) r_rebuild <= 1'b0;
                    end
                    ST_TWR: r_node <= NW'({1'b1, r_idx} >> 1);
                    default: r_lf_vld <= 1'b0;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ways      = r_ways;

    `MSTP_IMPLIES(a_done_in_mul, w_mm_done, r_state == ST_MUL, "product finished outside combine")
    `MSTP_NEXT(a_query_done, w_in_acc && !w_toggle_ok && !i_cfg_valid, r_state == ST_DONE, "query did not answer")
    `MSTP_IMPLIES(a_ways_range, o_out_valid, o_ways < P_MOD, "ways not reduced")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the segment tree path counter with a built-in matrix predictor.
`timescale 1ns / 1ps

module tb_top;
    import mstp_pkg::*;

    localparam int LEAF_BASE = 1024;
    localparam longint unsigned PRIME = 64'd1000000007;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
    } t_request;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             i_cmd = CMD_QUERY;
    logic [IDX_W-1:0] i_cell_index = '0;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [VAL_W-1:0] o_ways;
    logic             o_cfg_ready;

    t_request         pending_q[$];
    logic [VAL_W-1:0] ways_q[$];
    t_mat             node_mat[2*LEAF_BASE];
    bit               node_live[2*LEAF_BASE];
    bit               cell_shut[LEAF_BASE];
    int               live_cells;
    int               accepted;
    int               mismatches;
    bit               in_idle_en;
    bit               out_idle_en;

    matrix_segment_tree_path_counter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_cell_index(i_cell_index),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ways      (o_ways),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_mat mat_product(input t_mat a, input t_mat b);
        t_mat r;
        longint unsigned acc;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) begin
                    acc = (acc + (longint'(a[i*3+k]) * longint'(b[k*3+j])) % PRIME) % PRIME;
                end
                r[i*3+j] = acc[VAL_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic void load_leaf(input int i);
        t_mat m;
        m = '0;
        node_live[LEAF_BASE+i] = (i < live_cells);
        if (i < live_cells) begin
            if (cell_shut[i]) begin
                m[3] = 1; m[7] = 1;
            end else begin
                m[2] = 1; m[3] = 1; m[5] = 1; m[7] = 1; m[8] = 1;
            end
        end
        node_mat[LEAF_BASE+i] = m;
    endfunction

    function automatic void merge_node(input int n);
        if (!node_live[2*n]) begin
            node_live[n] = node_live[2*n+1];
            node_mat[n] = node_mat[2*n+1];
        end else if (!node_live[2*n+1]) begin
            node_live[n] = 1'b1;
            node_mat[n] = node_mat[2*n];
        end else begin
            node_live[n] = 1'b1;
            node_mat[n] = mat_product(node_mat[2*n], node_mat[2*n+1]);
        end
    endfunction

    function automatic void rebuild_tree(input int count);
        live_cells = (count > LEAF_BASE) ? LEAF_BASE : count;
        for (int i = 0; i < LEAF_BASE; i++) load_leaf(i);
        for (int n = LEAF_BASE - 1; n > 0; n--) merge_node(n);
    endfunction

    function automatic logic [VAL_W-1:0] apply_request(input t_request r);
        int n;
        if (r.cmd == CMD_TOGGLE && int'(r.idx) < live_cells) begin
            cell_shut[r.idx] = ~cell_shut[r.idx];
            load_leaf(r.idx);
            n = LEAF_BASE + r.idx;
            while (n > 1) begin
                n = n / 2;
                merge_node(n);
            end
        end
        return node_live[1] ? node_mat[1][8] : '0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                ways_q.push_back(apply_request('{cmd: i_cmd, idx: i_cell_index}));
                accepted++;
            end
            if (pending_q.size() > 0 && !(in_idle_en && $urandom_range(99) < 12)) begin
                t_request r;
                r = pending_q.pop_front();
                i_cmd <= r.cmd;
                i_cell_index <= r.idx;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (ways_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result: ways=%0d", o_ways);
                end else begin
                    logic [VAL_W-1:0] want;
                    want = ways_q.pop_front();
                    if (want !== o_ways) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ways mismatch: expected %0d, actual %0d", want, o_ways);
                        end
                    end
                end
            end
            i_out_stall <= out_idle_en && ($urandom_range(99) < 12);
        end
    end

    task automatic queue_random(input int count);
        t_request r;
        for (int k = 0; k < count; k++) begin
            r.cmd = ($urandom_range(99) < 75) ? CMD_TOGGLE : CMD_QUERY;
            if (live_cells > 0 && $urandom_range(99) < 88) begin
                r.idx = IDX_W'($urandom_range(live_cells - 1));
            end else begin
                r.idx = IDX_W'($urandom_range(1023));
            end
            pending_q.push_back(r);
        end
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || i_in_valid || ways_q.size() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        rebuild_tree(value);
    endtask

    initial begin
        logic [CFG_W-1:0] counts [8];
        counts = '{11'd1, 11'd0, 11'd2047, 11'd2, 11'd3, 11'd1000, 11'd5, 11'd1024};
        for (int i = 0; i < LEAF_BASE; i++) cell_shut[i] = 1'b0;
        rebuild_tree(CFG_RESET);
        in_idle_en = 1'b1;
        out_idle_en = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        pending_q.push_back('{CMD_QUERY, 10'd0});
        pending_q.push_back('{CMD_QUERY, 10'd1023});
        pending_q.push_back('{CMD_TOGGLE, 10'd0});
        pending_q.push_back('{CMD_TOGGLE, 10'd1023});
        pending_q.push_back('{CMD_TOGGLE, 10'd1});
        pending_q.push_back('{CMD_TOGGLE, 10'd2});
        pending_q.push_back('{CMD_QUERY, 10'd512});
        pending_q.push_back('{CMD_TOGGLE, 10'd1});
        pending_q.push_back('{CMD_TOGGLE, 10'd0});
        pending_q.push_back('{CMD_TOGGLE, 10'd511});
        pending_q.push_back('{CMD_TOGGLE, 10'd512});
        pending_q.push_back('{CMD_TOGGLE, 10'd1023});
        pending_q.push_back('{CMD_TOGGLE, 10'h2AA});
        pending_q.push_back('{CMD_TOGGLE, 10'h155});
        pending_q.push_back('{CMD_QUERY, 10'h3FF});
        queue_random(160);
        drain();
        for (int p = 0; p < 8; p++) begin
            write_count(counts[p]);
            if (p == 0) begin
                pending_q.push_back('{CMD_TOGGLE, 10'd0});
                pending_q.push_back('{CMD_TOGGLE, 10'd1});
                pending_q.push_back('{CMD_TOGGLE, 10'd1023});
                pending_q.push_back('{CMD_TOGGLE, 10'd0});
            end
            in_idle_en = (p != 5);
            out_idle_en = (p != 5);
            queue_random(170);
            drain();
        end
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
